[design/assert_macros.svh]
// assertion macros shared by the blend design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SGCB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgcb assertion failed");

// next-cycle implication, disabled during reset
`define SGCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgcb assertion failed");

`endif

[design/sgcb_pkg.sv]
// package: pipeline constants, lane control struct, srgb decode table generator and q30 math helpers
package sgcb_pkg;

  localparam int NUM_STAGES = 9;

  localparam logic [63:0] Q30_ONE = 64'h1 << 30;
  localparam logic [63:0] ENC_POW_DEN = 64'd2000 << 30;
  localparam logic [15:0] RECIP_257 = 16'hFF01;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic                  linear;
  } lane_ctl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'h1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (b > v) b = b >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // log2 in q30, truncated
  function automatic logic [63:0] log2_q30(input logic [63:0] n);
    logic [63:0] k;
    logic [63:0] m;
    logic [63:0] frac;
    k = 64'd0;
    frac = 64'd0;
    for (int s = 0; s < 63; s++) begin
      if ((n >> (k + 64'd1)) != 64'd0) k = k + 64'd1;
    end
    m = n << (64'd30 - k);
    for (int j = 1; j <= 30; j++) begin
      m = (m * m) >> 30;
      if (m >= 2 * Q30_ONE) begin
        m = m >> 1;
        frac = frac | (64'h1 << (30 - j));
      end
    end
    return (k << 30) | frac;
  endfunction

  // 2^g in q30, roots of two made by truncated square roots
  function automatic logic [63:0] exp2_q30(input logic [63:0] g);
    logic [63:0] r;
    logic [63:0] rt;
    r = Q30_ONE;
    rt = 2 * Q30_ONE;
    for (int j = 1; j <= 30; j++) begin
      rt = isqrt64(rt << 30);
      if (g[30-j]) r = (r * rt) >> 30;
    end
    return r;
  endfunction

  // (num/den)^e in q30, e is 12/5 when up is set, else 5/12
  function automatic logic [63:0] pow_q30(input logic [63:0] num, input logic [63:0] den,
                                          input logic up);
    logic [63:0] ln;
    logic [63:0] ld;
    logic [63:0] mag;
    logic [63:0] scaled;
    logic [63:0] whole;
    logic [63:0] fr;
    logic [63:0] e;
    logic [63:0] sh;
    if (num == 64'd0) return 64'd0;
    ln = log2_q30(num);
    ld = log2_q30(den);
    mag = (ld > ln) ? ld - ln : 64'd0;
    scaled = up ? mag * 12 / 5 : mag * 5 / 12;
    whole = scaled >> 30;
    fr = scaled & (Q30_ONE - 64'd1);
    if (fr == 64'd0) return (whole >= 64'd31) ? 64'd0 : Q30_ONE >> whole;
    e = exp2_q30(Q30_ONE - fr);
    sh = whole + 64'd1;
    return (sh >= 64'd63) ? 64'd0 : e >> sh;
  endfunction

  // srgb byte to 16-bit linear light
  function automatic logic [15:0] dec_entry(input int i);
    logic [63:0] iv;
    logic [63:0] p;
    logic [63:0] v;
    iv = 64'(i);
    if (iv <= 64'd10) begin
      v = (64'd655350 * iv * 2 + 64'd32946) / 64'd65892;
    end else begin
      p = pow_q30(64'd1000 * iv + 64'd14025, 64'd269025, 1'b1);
      v = (64'd65535 * p + (Q30_ONE >> 1)) >> 30;
    end
    if (v > 64'd65535) v = 64'd65535;
    return v[15:0];
  endfunction

endpackage

[design/sgcb_lane.sv]
// one color channel: decode, weighted blend, re-encode by table interpolation; srgb mode blends the bytes
module sgcb_lane #(
  parameter int ENCODE_TABLE_BITS    = 10,
  parameter int WEIGHT_FRACTION_BITS = 12
) (
  input  logic                          clk,
  input  sgcb_pkg::lane_ctl_t           ctl,
  input  logic [7:0]                    c0,
  input  logic [7:0]                    c1,
  input  logic [WEIGHT_FRACTION_BITS:0] a,
  output logic [7:0]                    blend
);

  localparam int AW = WEIGHT_FRACTION_BITS + 1;
  localparam int PW = AW + 16;
  localparam int SW = PW + 1;
  localparam int IW = ENCODE_TABLE_BITS + 1;
  localparam int EncSize = (1 << ENCODE_TABLE_BITS) + 1;
  localparam logic [63:0] EncN = 64'h1 << ENCODE_TABLE_BITS;
  localparam logic [63:0] EncDen = 64'd200 * EncN;
  localparam logic [AW-1:0] FullScale = {1'b1, {WEIGHT_FRACTION_BITS{1'b0}}};
  localparam logic [IW-1:0] IdxMax = {1'b1, {ENCODE_TABLE_BITS{1'b0}}};

  function automatic logic [15:0] enc_entry(input int k);
    logic [63:0] ki;
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] v;
    ki = 64'(k);
    if (ki * 64'd10000000 <= 64'd31308 * EncN) begin
      v = (64'd65535 * 64'd1292 * ki * 2 + 64'd100 * EncN) / EncDen;
    end else begin
      p = sgcb_pkg::pow_q30(ki, EncN, 1'b0);
      t = 64'd1055 * p;
      if (t <= 64'd55 * sgcb_pkg::Q30_ONE) begin
        v = 64'd0;
      end else begin
        v = (64'd65535 * (t - 64'd55 * sgcb_pkg::Q30_ONE) * 2 + 64'd1000 * sgcb_pkg::Q30_ONE)
            / sgcb_pkg::ENC_POW_DEN;
      end
    end
    if (v > 64'd65535) v = 64'd65535;
    return v[15:0];
  endfunction

  logic [15:0] dec_rom [256];
  logic [15:0] enc_rom [EncSize];

  for (genvar i = 0; i < 256; i++) begin : g_dec
    localparam logic [15:0] DecVal = sgcb_pkg::dec_entry(i);
    assign dec_rom[i] = DecVal;
  end

  for (genvar k = 0; k < EncSize; k++) begin : g_enc
    localparam logic [15:0] EncVal = enc_entry(k);
    assign enc_rom[k] = EncVal;
  end

  // stage 1
  logic [7:0]    c0_1_r, c1_1_r;
  logic [15:0]   l0_1_r, l1_1_r;
  logic [AW-1:0] a_1_r;
  logic          lin_1_r, zero_1_r, full_1_r;
  // stage 2
  logic [PW-1:0] p0_2_r, p1_2_r;
  logic [7:0]    fix_2_r;
  logic          byp_2_r, path_2_r;
  // stage 3
  logic [15:0]   lin_3_r;
  logic [7:0]    fix_3_r;
  logic          path_3_r;
  // stage 4
  logic [IW-1:0] idx_4_r;
  logic [15:0]   f_4_r;
  logic [7:0]    fix_4_r;
  logic          path_4_r;
  // stage 5
  logic [15:0]   t0_5_r, t1_5_r, f_5_r;
  logic [7:0]    fix_5_r;
  logic          path_5_r;
  // stage 6
  logic [31:0]   m0_6_r, m1_6_r;
  logic [7:0]    fix_6_r;
  logic          path_6_r;
  // stage 7
  logic [31:0]   sum_7_r;
  logic [7:0]    fix_7_r;
  logic          path_7_r;
  // stage 8
  logic [15:0]   y_8_r;
  logic [7:0]    fix_8_r;
  logic          path_8_r;
  // stage 9
  logic [7:0]    out_9_r;

  logic [15:0]   x0_nxt, x1_nxt;
  logic [AW-1:0] wrem_nxt;
  logic [SW-1:0] sum_nxt;
  logic [ENCODE_TABLE_BITS+15:0] pos_nxt;
  logic [ENCODE_TABLE_BITS-1:0]  q_nxt;
  logic [16:0]   r4_nxt;
  logic [IW-1:0] idx_nxt;
  logic [15:0]   f_nxt;
  logic [IW-1:0] addr1_nxt;
  logic [15:0]   q8_nxt;
  logic [16:0]   r8_nxt;
  logic [15:0]   y_nxt;
  logic [31:0]   prod_nxt;

  always_comb begin
    x0_nxt = lin_1_r ? l0_1_r : {8'd0, c0_1_r};
    x1_nxt = lin_1_r ? l1_1_r : {8'd0, c1_1_r};
    wrem_nxt = FullScale - a_1_r;
    sum_nxt = {1'b0, p0_2_r} + {1'b0, p1_2_r};
    pos_nxt = {lin_3_r, {ENCODE_TABLE_BITS{1'b0}}};
    q_nxt = pos_nxt[ENCODE_TABLE_BITS+15:16];
    r4_nxt = {1'b0, pos_nxt[15:0]} + 17'(q_nxt);
    if (r4_nxt >= 17'd65535) begin
      idx_nxt = IW'(q_nxt) + IW'(1);
      f_nxt = 16'(r4_nxt - 17'd65535);
    end else begin
      idx_nxt = IW'(q_nxt);
      f_nxt = r4_nxt[15:0];
    end
    addr1_nxt = (idx_4_r == IdxMax) ? idx_4_r : idx_4_r + IW'(1);
    q8_nxt = sum_7_r[31:16];
    r8_nxt = {1'b0, sum_7_r[15:0]} + {1'b0, q8_nxt};
    y_nxt = (r8_nxt >= 17'd65535) ? q8_nxt + 16'd1 : q8_nxt;
    prod_nxt = {16'd0, y_8_r} * {16'd0, sgcb_pkg::RECIP_257};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      c0_1_r   <= c0;
      c1_1_r   <= c1;
      l0_1_r   <= dec_rom[c0];
      l1_1_r   <= dec_rom[c1];
      a_1_r    <= a;
      lin_1_r  <= ctl.linear;
      zero_1_r <= (a == '0);
      full_1_r <= (a == FullScale);
    end
    if (ctl.en[1]) begin
      p0_2_r   <= PW'(wrem_nxt) * PW'(x0_nxt);
      p1_2_r   <= PW'(a_1_r) * PW'(x1_nxt);
      fix_2_r  <= zero_1_r ? c0_1_r : c1_1_r;
      byp_2_r  <= lin_1_r && (zero_1_r || full_1_r);
      path_2_r <= lin_1_r && !(zero_1_r || full_1_r);
    end
    if (ctl.en[2]) begin
      lin_3_r  <= 16'(sum_nxt >> WEIGHT_FRACTION_BITS);
      fix_3_r  <= byp_2_r ? fix_2_r : 8'(sum_nxt >> WEIGHT_FRACTION_BITS);
      path_3_r <= path_2_r;
    end
    if (ctl.en[3]) begin
      idx_4_r  <= idx_nxt;
      f_4_r    <= f_nxt;
      fix_4_r  <= fix_3_r;
      path_4_r <= path_3_r;
    end
    if (ctl.en[4]) begin
      t0_5_r   <= enc_rom[idx_4_r];
      t1_5_r   <= enc_rom[addr1_nxt];
      f_5_r    <= f_4_r;
      fix_5_r  <= fix_4_r;
      path_5_r <= path_4_r;
    end
    if (ctl.en[5]) begin
      m0_6_r   <= {16'd0, t0_5_r} * {16'd0, 16'hFFFF - f_5_r};
      m1_6_r   <= {16'd0, t1_5_r} * {16'd0, f_5_r};
      fix_6_r  <= fix_5_r;
      path_6_r <= path_5_r;
    end
    if (ctl.en[6]) begin
      sum_7_r  <= m0_6_r + m1_6_r;
      fix_7_r  <= fix_6_r;
      path_7_r <= path_6_r;
    end
    if (ctl.en[7]) begin
      y_8_r    <= y_nxt;
      fix_8_r  <= fix_7_r;
      path_8_r <= path_7_r;
    end
    if (ctl.en[8]) begin
      out_9_r  <= path_8_r ? prod_nxt[31:24] : fix_8_r;
    end
  end

  assign blend = out_9_r;

endmodule

[design/srgb_gamma_correct_color_blend.sv]
// top level: srgb blend in linear light or srgb space, three lanes behind one valid pipeline
// nine register stages from input accept to out_tvalid
// throughput: one item per clock unless a full pipeline waits on out_tready; each stage advances
// when it is empty or the next one advances, so bubbles close up while the output waits
// reset: clears all stage valid bits and sets blend_space to linear light
module srgb_gamma_correct_color_blend #(
  parameter int ENCODE_TABLE_BITS    = 10,
  parameter int WEIGHT_FRACTION_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // first_red, first_green, first_blue, second_red, second_green, second_blue,
  // weight[12:0], zero pad
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // blend_red, blend_green, blend_blue
  output logic [23:0] out_tdata
);

  `include "assert_macros.svh"

  localparam int NS = sgcb_pkg::NUM_STAGES;
  localparam int AW = WEIGHT_FRACTION_BITS + 1;
  localparam int CmpW = (AW > 13) ? AW : 13;
  localparam logic [CmpW-1:0] FullScaleW = CmpW'(1) << WEIGHT_FRACTION_BITS;

  logic          blend_space_r;
  logic [NS-1:0] v_r, v_nxt, en;
  logic [CmpW-1:0] weight_ext;
  logic [AW-1:0] a_sat;
  sgcb_pkg::lane_ctl_t ctl;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < NS; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r           <= '0;
      blend_space_r <= 1'b1;
    end else begin
      v_r <= v_nxt;
      if (cfg_wr_en) begin
        blend_space_r <= cfg_wr_data;
      end
    end
  end

  assign weight_ext = CmpW'(in_tdata[60:48]);
  assign a_sat = AW'((weight_ext > FullScaleW) ? FullScaleW : weight_ext);
  assign ctl.en = en;
  assign ctl.linear = blend_space_r;

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    sgcb_lane #(
      .ENCODE_TABLE_BITS   (ENCODE_TABLE_BITS),
      .WEIGHT_FRACTION_BITS(WEIGHT_FRACTION_BITS)
    ) u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .c0   (in_tdata[8*ch +: 8]),
      .c1   (in_tdata[8*ch + 24 +: 8]),
      .a    (a_sat),
      .blend(out_tdata[8*ch +: 8])
    );
  end

  assign in_tready = en[0];
  assign out_tvalid = v_r[NS-1];

  `SGCB_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, v_r[0])
  `SGCB_ASSERT_IMPL(a_stall_only_full, !in_tready, (&v_r) && !out_tready)
  `SGCB_ASSERT_NEXT(a_last_step_lands, v_r[NS-2] && en[NS-1], out_tvalid)

endmodule
